@@ rtl/core/cle_pkg.sv @@
// Shared types, codes and defaults for the cursor list engine.
package cle_pkg;

    localparam int DEF_CAPACITY   = 64;
    localparam int DEF_DATA_WIDTH = 32;

    typedef enum logic [3:0] {
        MODE_INSERT  = 4'd0,
        MODE_REMOVE  = 4'd1,
        MODE_REPLACE = 4'd2,
        MODE_CLEAR   = 4'd3,
        MODE_BEGIN   = 4'd4,
        MODE_END     = 4'd5,
        MODE_NEXT    = 4'd6,
        MODE_PRIOR   = 4'd7,
        MODE_READ    = 4'd8,
        MODE_MOVE    = 4'd9,
        MODE_FIND    = 4'd10
    } mode_t;

    typedef enum logic [1:0] {
        STAT_OK     = 2'd0,
        STAT_FULL   = 2'd1,
        STAT_EMPTY  = 2'd2,
        STAT_BADPOS = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MV_LATCH,
        ST_SH_PRIME,
        ST_SH_RUN,
        ST_TAIL,
        ST_FD_RUN,
        ST_FETCH,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [5:0]  position;
        logic [31:0] data_value;
        logic [3:0]  mode;
    } cmd_t;

    typedef struct packed {
        logic [5:0]  cursor_out;
        logic [6:0]  count_out;
        status_t     status;
        logic        success;
        logic [31:0] read_value;
    } result_t;

endpackage

@@ rtl/core/cle_ram.sv @@
// Generic simple dual-port RAM, one write and one registered read port.
module cle_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ rtl/core/cle_ctrl.sv @@
// Sequencer for the cursor list: one step unit drives shifts and scans over the RAM.
module cle_ctrl #(
    parameter int CAPACITY   = cle_pkg::DEF_CAPACITY,
    parameter int DATA_WIDTH = cle_pkg::DEF_DATA_WIDTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  cle_pkg::cmd_t    cmd,
    input  logic             cmd_valid,
    output logic             cmd_ready,
    output cle_pkg::result_t res,
    output logic             res_valid,
    input  logic             res_ready
);

    import cle_pkg::*;

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int DW = DATA_WIDTH;

    state_t         state_reg, state_next;
    logic [3:0]     mode_reg, mode_next;
    logic [DW-1:0]  val_reg, val_next;
    logic [5:0]     pos_reg, pos_next;
    logic [DW-1:0]  moved_reg, moved_next;
    logic [CW-1:0]  count_reg, count_next;
    logic [IW-1:0]  cur_reg, cur_next;
    logic [IW-1:0]  ptr_reg, ptr_next;
    logic [IW-1:0]  dst_reg, dst_next;
    logic [IW-1:0]  last_reg, last_next;
    logic           inc_reg, inc_next;
    status_t        status_reg, status_next;
    logic           success_reg, success_next;

    logic           wr_en;
    logic [IW-1:0]  wr_addr;
    logic [DW-1:0]  wr_data;
    logic           rd_en;
    logic [IW-1:0]  rd_addr;
    logic [DW-1:0]  rd_data;

    logic           cnt_zero;
    logic           cnt_full;
    logic [CW-1:0]  cur_ext;
    logic [CW-1:0]  cur_p1;
    logic           cmd_pos_bad;
    logic           pos_gt_cur;
    logic           pos_lt_cur;
    logic [IW-1:0]  step;
    logic           find_last;
    logic           hit;
    logic [DW-1:0]  cmd_val;

    cle_ram #(
        .WIDTH (DW),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign cnt_zero    = (count_reg == '0);
    assign cnt_full    = (count_reg == CW'(CAPACITY));
    assign cur_ext     = CW'(cur_reg);
    assign cur_p1      = cur_ext + CW'(1);
    assign cmd_pos_bad = (32'(cmd.position) >= 32'(count_reg));
    assign pos_gt_cur  = (32'(pos_reg) > 32'(cur_reg));
    assign pos_lt_cur  = (32'(pos_reg) < 32'(cur_reg));
    assign cmd_val     = DW'(cmd.data_value);

    // shared step unit: one index up or down
    assign step      = inc_reg ? (ptr_reg + IW'(1)) : (ptr_reg - IW'(1));
    assign find_last = ((CW'(ptr_reg) + CW'(1)) == count_reg);
    assign hit       = (rd_data == val_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    case (cmd.mode)
                        MODE_INSERT:
                        begin
                            if (cnt_full || cnt_zero)
                                state_next = ST_FETCH;
                            else if (count_reg > cur_p1)
                                state_next = ST_SH_PRIME;
                            else
                                state_next = ST_TAIL;
                        end
                        MODE_REMOVE:
                        begin
                            if (cnt_zero)
                                state_next = ST_FETCH;
                            else if (cur_p1 < count_reg)
                                state_next = ST_SH_PRIME;
                            else
                                state_next = ST_TAIL;
                        end
                        MODE_MOVE:
                        begin
                            if (cnt_zero || cmd_pos_bad)
                                state_next = ST_FETCH;
                            else
                                state_next = ST_MV_LATCH;
                        end
                        MODE_FIND:
                        begin
                            state_next = cnt_zero ? ST_FETCH : ST_FD_RUN;
                        end
                        default:
                        begin
                            state_next = ST_FETCH;
                        end
                    endcase
                end
            end
            ST_MV_LATCH:
            begin
                state_next = (pos_gt_cur || pos_lt_cur) ? ST_SH_PRIME : ST_TAIL;
            end
            ST_SH_PRIME:
            begin
                state_next = ST_SH_RUN;
            end
            ST_SH_RUN:
            begin
                if (dst_reg == last_reg)
                    state_next = ST_TAIL;
            end
            ST_TAIL:
            begin
                state_next = ST_FETCH;
            end
            ST_FD_RUN:
            begin
                if (hit || find_last)
                    state_next = ST_FETCH;
            end
            ST_FETCH:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (res_ready)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and RAM controls
    always_comb
    begin
        mode_next    = mode_reg;
        val_next     = val_reg;
        pos_next     = pos_reg;
        moved_next   = moved_reg;
        count_next   = count_reg;
        cur_next     = cur_reg;
        ptr_next     = ptr_reg;
        dst_next     = dst_reg;
        last_next    = last_reg;
        inc_next     = inc_reg;
        status_next  = status_reg;
        success_next = success_reg;
        wr_en        = 1'b0;
        wr_addr      = cur_reg;
        wr_data      = val_reg;
        rd_en        = 1'b0;
        rd_addr      = cur_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    mode_next    = cmd.mode;
                    val_next     = cmd_val;
                    pos_next     = cmd.position;
                    status_next  = STAT_OK;
                    success_next = 1'b0;
                    if (cnt_zero && cmd.mode != MODE_INSERT && cmd.mode != MODE_CLEAR
                        && cmd.mode <= MODE_FIND)
                    begin
                        status_next = STAT_EMPTY;
                    end
                    else
                    begin
                        case (cmd.mode)
                            MODE_INSERT:
                            begin
                                if (cnt_full)
                                begin
                                    status_next = STAT_FULL;
                                end
                                else if (cnt_zero)
                                begin
                                    wr_en      = 1'b1;
                                    wr_addr    = '0;
                                    wr_data    = cmd_val;
                                    count_next = CW'(1);
                                    cur_next   = '0;
                                end
                                else
                                begin
                                    ptr_next  = IW'(count_reg);
                                    inc_next  = 1'b0;
                                    last_next = IW'(cur_ext + CW'(2));
                                end
                            end
                            MODE_CLEAR:
                            begin
                                count_next = '0;
                                cur_next   = '0;
                            end
                            MODE_REMOVE:
                            begin
                                ptr_next  = cur_reg;
                                inc_next  = 1'b1;
                                last_next = IW'(count_reg - CW'(2));
                            end
                            MODE_REPLACE:
                            begin
                                wr_en   = 1'b1;
                                wr_addr = cur_reg;
                                wr_data = cmd_val;
                            end
                            MODE_BEGIN:
                            begin
                                cur_next = '0;
                            end
                            MODE_END:
                            begin
                                cur_next = IW'(count_reg - CW'(1));
                            end
                            MODE_NEXT:
                            begin
                                if (cur_p1 < count_reg)
                                begin
                                    cur_next     = cur_reg + IW'(1);
                                    success_next = 1'b1;
                                end
                            end
                            MODE_PRIOR:
                            begin
                                if (cur_reg != '0)
                                begin
                                    cur_next     = cur_reg - IW'(1);
                                    success_next = 1'b1;
                                end
                            end
                            MODE_MOVE:
                            begin
                                if (cmd_pos_bad)
                                begin
                                    status_next = STAT_BADPOS;
                                end
                                else
                                begin
                                    rd_en   = 1'b1;
                                    rd_addr = cur_reg;
                                end
                            end
                            MODE_FIND:
                            begin
                                rd_en    = 1'b1;
                                rd_addr  = '0;
                                ptr_next = '0;
                                inc_next = 1'b1;
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
            end
            ST_MV_LATCH:
            begin
                moved_next = rd_data;
                ptr_next   = cur_reg;
                if (pos_gt_cur)
                begin
                    inc_next  = 1'b1;
                    last_next = IW'(pos_reg) - IW'(1);
                end
                else
                begin
                    inc_next  = 1'b0;
                    last_next = IW'(pos_reg) + IW'(1);
                end
            end
            ST_SH_PRIME:
            begin
                rd_en    = 1'b1;
                rd_addr  = step;
                ptr_next = step;
                dst_next = ptr_reg;
            end
            ST_SH_RUN:
            begin
                wr_en   = 1'b1;
                wr_addr = dst_reg;
                wr_data = rd_data;
                if (dst_reg != last_reg)
                begin
                    rd_en    = 1'b1;
                    rd_addr  = step;
                    ptr_next = step;
                    dst_next = ptr_reg;
                end
            end
            ST_TAIL:
            begin
                case (mode_reg)
                    MODE_INSERT:
                    begin
                        wr_en      = 1'b1;
                        wr_addr    = cur_reg + IW'(1);
                        wr_data    = val_reg;
                        cur_next   = cur_reg + IW'(1);
                        count_next = count_reg + CW'(1);
                    end
                    MODE_REMOVE:
                    begin
                        count_next = count_reg - CW'(1);
                        if (cur_reg != '0)
                            cur_next = cur_reg - IW'(1);
                    end
                    MODE_MOVE:
                    begin
                        wr_en    = 1'b1;
                        wr_addr  = IW'(pos_reg);
                        wr_data  = moved_reg;
                        cur_next = IW'(pos_reg);
                    end
                    default:
                    begin
                    end
                endcase
            end
            ST_FD_RUN:
            begin
                if (hit)
                begin
                    cur_next     = ptr_reg;
                    success_next = 1'b1;
                end
                else if (find_last)
                begin
                    cur_next = '0;
                end
                else
                begin
                    rd_en    = 1'b1;
                    rd_addr  = step;
                    ptr_next = step;
                end
            end
            ST_FETCH:
            begin
                rd_en   = !cnt_zero;
                rd_addr = cur_reg;
            end
            default:
            begin
            end
        endcase
    end

    assign cmd_ready      = (state_reg == ST_IDLE);
    assign res_valid      = (state_reg == ST_DONE);
    assign res.read_value = cnt_zero ? 32'd0 : 32'(rd_data);
    assign res.success    = success_reg;
    assign res.status     = status_reg;
    assign res.count_out  = 7'(count_reg);
    assign res.cursor_out = 6'(cur_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            cur_reg     <= '0;
            status_reg  <= STAT_OK;
            success_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            cur_reg     <= cur_next;
            status_reg  <= status_next;
            success_reg <= success_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg  <= mode_next;
        val_reg   <= val_next;
        pos_reg   <= pos_next;
        moved_reg <= moved_next;
        ptr_reg   <= ptr_next;
        dst_reg   <= dst_next;
        last_reg  <= last_next;
        inc_reg   <= inc_next;
    end

endmodule

@@ rtl/core/cursor_list_engine.sv @@
// Top level of the cursor list engine: stream ports, sequencer and output register.
// Simple commands and errors go straight to the read of the cursor entry; insert and remove
// first shift any entries after the cursor, move shifts those between cursor and target,
// and find reads from index 0 up to the first match or the last entry.
// Shifts and scans use the one RAM port pair: one entry read and one written per cycle.
// Commands are taken one at a time; s_tready is high only while the sequencer is idle.
// Reset (rst_n low, async) empties the list and sets the cursor to 0; the RAM is not cleared.
module cursor_list_engine #(
    parameter int CAPACITY   = cle_pkg::DEF_CAPACITY,
    parameter int DATA_WIDTH = cle_pkg::DEF_DATA_WIDTH
) (
    input  logic        clk,
    input  logic        rst_n,
    // slave side: one command per transfer
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // data_value[31:0], position[37:32], zero pad
    input  logic [3:0]  s_tuser,   // mode[3:0]
    // master side: one result per command
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata    // read_value[31:0], success[32], status[34:33],
                                   // count_out[41:35], cursor_out[47:42]
);

    import cle_pkg::*;

    cmd_t    cmd;
    result_t res;
    logic    res_valid;
    logic    res_ready;
    logic    out_valid_reg;
    logic [47:0] out_data_reg;

    assign cmd.mode       = s_tuser;
    assign cmd.data_value = s_tdata[31:0];
    assign cmd.position   = s_tdata[37:32];

    cle_ctrl #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .cmd_valid (s_tvalid),
        .cmd_ready (s_tready),
        .res       (res),
        .res_valid (res_valid),
        .res_ready (res_ready)
    );

    // output register: sequencer frees up as soon as the result is parked here
    assign res_ready = !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            out_data_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

@@ test/tb_cursor_list_engine.sv @@
// Self-checking testbench for cursor_list_engine: directed table plus random command mix.
module tb_cursor_list_engine;
    timeunit 1ns;
    timeprecision 1ps;

    import cle_pkg::*;

    localparam int CAPACITY       = DEF_CAPACITY;
    localparam int RAND_ITEMS     = 1750;
    localparam int PHASE_LEN      = 150;      // items per traffic profile
    localparam int RX_HOLD_CYCLES = 300;      // long output back-pressure window
    localparam int HOLD_AT_ITEM   = 600;
    localparam int PAUSE_AT_ITEM  = 1000;
    localparam int SETTLE_CYCLES  = 2 * CAPACITY + 16;
    localparam int CYCLE_LIMIT    = 1_000_000;

    // Codes 11..15 have no meaning; the block must answer them with no change.
    localparam logic [3:0] MODE_UNUSED_LO = 4'd11;
    localparam logic [3:0] MODE_UNUSED_HI = 4'd15;

    // Small value pool so that finds meet duplicates and must report the first one.
    localparam logic [31:0] DUP_BASE = 32'hC0DE_0000;

    typedef enum int { MIX_FILL, MIX_EVEN, MIX_DRAIN } traffic_mix_t;

    typedef struct {
        logic [3:0]  mode;
        logic [31:0] value;
        logic [5:0]  pos;
        bit          typed;       // expected result given in the table itself
        result_t     res;
    } step_row_t;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata  = '0;
    logic [3:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;

    // Shadow copy of the list, advanced once per accepted command.
    logic [31:0] lst_data [CAPACITY];
    int          lst_count  = 0;
    int          lst_cursor = 0;

    result_t     results_due [$];   // expected results, oldest first
    step_row_t   directed_plan [$];

    bit          quiet       = 1'b0;  // both sides stop idling while set
    bit          rx_hold_req = 1'b0;  // asks the receiver for a long hold-off
    int          mismatches  = 0;
    int          results_seen = 0;
    int          cmds_sent   = 0;
    int          full_hits   = 0;
    int          max_fill    = 0;
    int          cycle_count = 0;

    cursor_list_engine dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Watchdog: a hung handshake or a lost result ends here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Apply one command to the shadow list and return the result it must produce.
    function automatic result_t list_apply(logic [3:0] mode, logic [31:0] value,
                                           logic [5:0] pos);
        result_t     r;
        logic [31:0] moved;
        int          i;
        bit          hit;
        r = '0;
        r.status = STAT_OK;
        hit = 1'b0;
        if (mode == MODE_INSERT)
        begin
            if (lst_count >= CAPACITY)
                r.status = STAT_FULL;
            else if (lst_count == 0)
            begin
                lst_data[0] = value;
                lst_count   = 1;
                lst_cursor  = 0;
            end
            else
            begin
                // open a slot just after the cursor
                for (i = lst_count; i > lst_cursor + 1; i--)
                    lst_data[i] = lst_data[i - 1];
                lst_cursor++;
                lst_data[lst_cursor] = value;
                lst_count++;
            end
        end
        else if (mode == MODE_CLEAR)
        begin
            lst_count  = 0;
            lst_cursor = 0;
        end
        else if (mode <= MODE_FIND && lst_count == 0)
            r.status = STAT_EMPTY;
        else
        begin
            case (mode)
                MODE_REMOVE:
                begin
                    for (i = lst_cursor; i + 1 < lst_count; i++)
                        lst_data[i] = lst_data[i + 1];
                    lst_count--;
                    if (lst_cursor > 0)
                        lst_cursor--;
                end
                MODE_REPLACE: lst_data[lst_cursor] = value;
                MODE_BEGIN:   lst_cursor = 0;
                MODE_END:     lst_cursor = lst_count - 1;
                MODE_NEXT:
                begin
                    if (lst_cursor + 1 < lst_count)
                    begin
                        lst_cursor++;
                        r.success = 1'b1;
                    end
                end
                MODE_PRIOR:
                begin
                    if (lst_cursor > 0)
                    begin
                        lst_cursor--;
                        r.success = 1'b1;
                    end
                end
                MODE_MOVE:
                begin
                    if (int'(pos) >= lst_count)
                        r.status = STAT_BADPOS;
                    else
                    begin
                        moved = lst_data[lst_cursor];
                        if (int'(pos) > lst_cursor)
                            for (i = lst_cursor; i < int'(pos); i++)
                                lst_data[i] = lst_data[i + 1];
                        else
                            for (i = lst_cursor; i > int'(pos); i--)
                                lst_data[i] = lst_data[i - 1];
                        lst_data[pos] = moved;
                        lst_cursor    = pos;
                    end
                end
                MODE_FIND:
                begin
                    // first match from index 0; a miss parks the cursor at 0
                    lst_cursor = 0;
                    for (i = 0; i < lst_count; i++)
                    begin
                        if (!hit && lst_data[i] == value)
                        begin
                            lst_cursor = i;
                            hit        = 1'b1;
                        end
                    end
                    r.success = hit;
                end
                default: ;   // read and unused codes leave the list alone
            endcase
        end

        if (lst_count == 0)
            lst_cursor = 0;

        r.read_value = (lst_count == 0) ? 32'h0 : lst_data[lst_cursor];
        r.count_out  = 7'(lst_count);
        r.cursor_out = 6'(lst_cursor);
        return r;
    endfunction

    function automatic result_t known_res(logic [31:0] rv, logic ok_flag, status_t st,
                                          int cnt, int cur);
        result_t r;
        r.read_value = rv;
        r.success    = ok_flag;
        r.status     = st;
        r.count_out  = 7'(cnt);
        r.cursor_out = 6'(cur);
        return r;
    endfunction

    function automatic void plan_step(logic [3:0] mode, logic [31:0] value, logic [5:0] pos,
                                      bit typed = 1'b0, result_t res = '0);
        step_row_t row;
        row.mode  = mode;
        row.value = value;
        row.pos   = pos;
        row.typed = typed;
        row.res   = res;
        directed_plan.push_back(row);
    endfunction

    // Offer one command, hold it until the transfer completes, then queue its result.
    task automatic send_cmd(input logic [3:0] mode, input logic [31:0] value,
                            input logic [5:0] pos, input bit typed, input result_t res);
        result_t predicted;
        while (!quiet && $urandom_range(99) < 30)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {2'b00, pos, value};
        do
            @(posedge clk);
        while (!s_tready);
        // transfer taken at this edge: the shadow list moves on in the same order
        predicted = list_apply(mode, value, pos);
        results_due.push_back(typed ? res : predicted);
        cmds_sent++;
        if (mode == MODE_INSERT && predicted.status == STAT_FULL)
            full_hits++;
        if (lst_count > max_fill)
            max_fill = lst_count;
    endtask

    // Result side: random back-pressure, plus one long hold-off on request so the
    // block backs up and must drop s_tready while the sender keeps offering.
    initial
    begin : rx_side
        int unsigned held;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (rx_hold_req)
            begin
                m_tready <= 1'b0;
                for (held = 0; held < RX_HOLD_CYCLES; held++)
                    @(posedge clk);
                rx_hold_req = 1'b0;
            end
            m_tready <= quiet || ($urandom_range(99) >= 30);
        end
    end

    // Every result transfer is compared with the oldest outstanding expectation.
    always @(posedge clk)
    begin : result_check
        result_t got;
        result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = result_t'(m_tdata);
            results_seen++;
            if (results_due.size() == 0)
            begin
                $error("result %h arrived with nothing outstanding", m_tdata);
                mismatches++;
            end
            else
            begin
                want = results_due.pop_front();
                if (got.read_value !== want.read_value)
                begin
                    $error("read_value: expected %h, got %h", want.read_value, got.read_value);
                    mismatches++;
                end
                if (got.success !== want.success)
                begin
                    $error("success: expected %0d, got %0d", want.success, got.success);
                    mismatches++;
                end
                if (got.status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, got.status);
                    mismatches++;
                end
                if (got.count_out !== want.count_out)
                begin
                    $error("count_out: expected %0d, got %0d", want.count_out, got.count_out);
                    mismatches++;
                end
                if (got.cursor_out !== want.cursor_out)
                begin
                    $error("cursor_out: expected %0d, got %0d", want.cursor_out, got.cursor_out);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin : stimulus
        int           n;
        int           roll;
        int           pick;
        int           ins_pct;
        int           rem_pct;
        int           phase_idx;
        traffic_mix_t profile;
        logic [3:0]   mode;
        logic [31:0]  value;
        logic [5:0]   pos;

        profile = MIX_FILL;
        ins_pct = 75;
        rem_pct = 5;

        // Directed part: empty-list errors, extremes, edge moves of the cursor.
        plan_step(MODE_READ,   32'h0, 6'd0,  1'b1, known_res(32'h0, 1'b0, STAT_EMPTY, 0, 0));
        plan_step(MODE_REMOVE, 32'h0, 6'd0,  1'b1, known_res(32'h0, 1'b0, STAT_EMPTY, 0, 0));
        plan_step(MODE_MOVE,   32'h0, 6'd63, 1'b1, known_res(32'h0, 1'b0, STAT_EMPTY, 0, 0));
        plan_step(MODE_NEXT,   32'h0, 6'd0,  1'b1, known_res(32'h0, 1'b0, STAT_EMPTY, 0, 0));
        plan_step(MODE_FIND,   32'h0, 6'd0,  1'b1, known_res(32'h0, 1'b0, STAT_EMPTY, 0, 0));
        plan_step(MODE_UNUSED_HI, 32'hFFFF_FFFF, 6'd63, 1'b1,
                  known_res(32'h0, 1'b0, STAT_OK, 0, 0));
        plan_step(MODE_INSERT, 32'hFFFF_FFFF, 6'd0, 1'b1,
                  known_res(32'hFFFF_FFFF, 1'b0, STAT_OK, 1, 0));
        plan_step(MODE_INSERT, 32'h0, 6'd0, 1'b1, known_res(32'h0, 1'b0, STAT_OK, 2, 1));
        plan_step(MODE_INSERT,  32'h5A5A_5A5A, 6'd0);
        plan_step(MODE_PRIOR,   32'h0, 6'd0);
        plan_step(MODE_INSERT,  32'h1234_5678, 6'd0);  // lands mid-list, tail shifts up
        plan_step(MODE_BEGIN,   32'h0, 6'd0);
        plan_step(MODE_PRIOR,   32'h0, 6'd0);           // already at the head
        plan_step(MODE_END,     32'h0, 6'd0);
        plan_step(MODE_NEXT,    32'h0, 6'd0);           // already at the tail
        plan_step(MODE_REPLACE, 32'hA5A5_A5A5, 6'd0);
        plan_step(MODE_FIND,    32'h0, 6'd0);           // hit
        plan_step(MODE_FIND,    32'h8765_4321, 6'd0);   // miss sends cursor home
        plan_step(MODE_MOVE,    32'h0, 6'd63);          // position past the end
        plan_step(MODE_MOVE,    32'h0, 6'd3);           // head entry to the tail
        plan_step(MODE_MOVE,    32'h0, 6'd0);           // tail entry back to the head
        plan_step(MODE_UNUSED_LO, 32'h0, 6'd0);
        plan_step(MODE_REMOVE,  32'h0, 6'd0);           // cursor at 0 stays at 0
        plan_step(MODE_READ,    32'h0, 6'd0);
        plan_step(MODE_CLEAR,   32'hFFFF_FFFF, 6'd63, 1'b1,
                  known_res(32'h0, 1'b0, STAT_OK, 0, 0));

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_plan[k])
            send_cmd(directed_plan[k].mode, directed_plan[k].value, directed_plan[k].pos,
                     directed_plan[k].typed, directed_plan[k].res);

        // Random part: profiles rotate fill / even / drain / even so the list
        // repeatedly runs up to full and back down to empty.
        for (n = 0; n < RAND_ITEMS; n++)
        begin
            if (n % PHASE_LEN == 0)
            begin
                phase_idx = n / PHASE_LEN;
                case (phase_idx % 4)
                    0:       profile = MIX_FILL;
                    2:       profile = MIX_DRAIN;
                    default: profile = MIX_EVEN;
                endcase
                case (profile)
                    MIX_FILL:  begin ins_pct = 75; rem_pct = 5;  end
                    MIX_DRAIN: begin ins_pct = 10; rem_pct = 55; end
                    default:   begin ins_pct = 35; rem_pct = 30; end
                endcase
                quiet = (phase_idx == 2);   // one stretch with no idling on either side
            end

            if (n == HOLD_AT_ITEM)
                rx_hold_req = 1'b1;

            if (n == PAUSE_AT_ITEM)
            begin
                // sender goes quiet until every outstanding result is back
                s_tvalid <= 1'b0;
                do
                    @(posedge clk);
                while (results_due.size() != 0);
            end

            roll  = $urandom_range(99);
            pos   = 6'($urandom_range(63));
            value = $urandom();
            if (roll < ins_pct)
            begin
                mode = MODE_INSERT;
                if ($urandom_range(9) < 3)
                    value = DUP_BASE + $urandom_range(7);
            end
            else if (roll < ins_pct + rem_pct)
                mode = MODE_REMOVE;
            else
            begin
                pick = $urandom_range(39);
                if (pick < 10)
                begin
                    mode = MODE_FIND;
                    // mostly search for something that is really there
                    if (lst_count > 0 && $urandom_range(9) < 7)
                        value = lst_data[$urandom_range(lst_count - 1)];
                    else if ($urandom_range(1) == 1)
                        value = DUP_BASE + $urandom_range(7);
                end
                else if (pick < 16)
                begin
                    mode = MODE_MOVE;
                    if (lst_count > 0 && $urandom_range(99) < 85)
                        pos = 6'($urandom_range(lst_count - 1));
                end
                else if (pick < 21)
                    mode = MODE_NEXT;
                else if (pick < 26)
                    mode = MODE_PRIOR;
                else if (pick < 30)
                    mode = MODE_REPLACE;
                else if (pick < 32)
                    mode = MODE_BEGIN;
                else if (pick < 34)
                    mode = MODE_END;
                else if (pick < 37)
                    mode = MODE_READ;
                else if (pick < 39)
                    mode = 4'($urandom_range(MODE_UNUSED_HI, MODE_UNUSED_LO));
                else
                    mode = MODE_CLEAR;
            end
            send_cmd(mode, value, pos, 1'b0, '0);
        end

        s_tvalid <= 1'b0;
        while (results_due.size() != 0)
            @(posedge clk);
        // let any stray late result show up before judging
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Sent %0d commands, checked %0d results; list peaked at %0d entries, %0d inserts refused as full.",
                 cmds_sent, results_seen, max_fill, full_hits);
        $display("Traffic rotated fill/even/drain mixes with a %0d-cycle output hold-off and a drain-to-empty pause.",
                 RX_HOLD_CYCLES);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
